### rtl/wsfe_pkg.sv
// Shared types, constants and helpers for the WebSocket frame encoder.
package wsfe_pkg;

    localparam logic [6:0]  LEN_CODE_16 = 7'd126;
    localparam logic [6:0]  LEN_CODE_64 = 7'd127;
    localparam logic [31:0] LEN_16_MAX  = 32'h0000_FFFF;
    localparam logic        MASK_BIT    = 1'b1;

    // Index of the last header byte for each length class.
    localparam logic [3:0]  HDR_LAST_7  = 4'd5;
    localparam logic [3:0]  HDR_LAST_16 = 4'd7;
    localparam logic [3:0]  HDR_LAST_64 = 4'd13;

    typedef enum logic [1:0] {
        LEN_7  = 2'd0,
        LEN_16 = 2'd1,
        LEN_64 = 2'd2
    } t_len_class;

    // One queued job: a whole header burst or one finished payload byte.
    typedef struct packed {
        logic        is_hdr;
        t_len_class  len_class;
        logic [7:0]  first_byte;  // fin/opcode byte, or the payload byte (masked unless overrun)
        logic        frame_end;   // header: length is zero; payload: last byte
        logic        overrun;
        logic [31:0] length;
        logic [31:0] key;
    } t_cmd;

    // Key byte for a phase, first byte in bits 31..24.
    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] phase);
        logic [7:0] b;
        case (phase)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

### rtl/wsfe_front.sv
// Front end: classifies input words, tracks frame state, builds queued jobs.
module wsfe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_mode,
    input  logic             i_final_flag,
    input  logic [3:0]       i_frame_opcode,
    input  logic [31:0]      i_payload_length,
    input  logic [31:0]      i_mask_key,
    input  logic [7:0]       i_data_byte,
    output logic             o_push,
    output wsfe_pkg::t_cmd   o_cmd
);
    import wsfe_pkg::*;

    logic [31:0] r_remaining, n_remaining;
    logic [1:0]  r_phase,     n_phase;
    logic [31:0] r_key,       n_key;

    always_comb begin
        n_remaining = r_remaining;
        n_phase     = r_phase;
        n_key       = r_key;

        o_cmd            = '0;
        o_cmd.length     = i_payload_length;
        o_cmd.key        = i_mask_key;

        if (!i_mode) begin
            o_cmd.is_hdr     = 1'b1;
            o_cmd.first_byte = {i_final_flag, 3'b000, i_frame_opcode};
            o_cmd.frame_end  = (i_payload_length == 32'd0);
            if (i_payload_length < {25'd0, LEN_CODE_16}) begin
                o_cmd.len_class = LEN_7;
            end else if (i_payload_length <= LEN_16_MAX) begin
                o_cmd.len_class = LEN_16;
            end else begin
                o_cmd.len_class = LEN_64;
            end
            n_remaining = i_payload_length;
            n_phase     = 2'd0;
            n_key       = i_mask_key;
        end else if (r_remaining == 32'd0) begin
            // nothing left in frame: pass through unmasked and flag it
            o_cmd.first_byte = i_data_byte;
            o_cmd.overrun    = 1'b1;
        end else begin
            o_cmd.first_byte = i_data_byte ^ key_byte(r_key, r_phase);
            o_cmd.frame_end  = (r_remaining == 32'd1);
            n_remaining      = r_remaining - 32'd1;
            n_phase          = r_phase + 2'd1;
        end
    end

    assign o_push = i_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_phase     <= '0;
            r_key       <= '0;
        end else if (i_accept) begin
            r_remaining <= n_remaining;
            r_phase     <= n_phase;
            r_key       <= n_key;
        end
    end

endmodule

### rtl/wsfe_queue.sv
// Small job queue between the front end and the byte sequencer.
module wsfe_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsfe_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output wsfe_pkg::t_cmd   o_cmd
);
    import wsfe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

endmodule

### rtl/wsfe_back.sv
// Back end: walks header jobs byte by byte and drives the output register.
module wsfe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  wsfe_pkg::t_cmd   i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_is_header,
    output logic             o_frame_end,
    output logic             o_overrun
);
    import wsfe_pkg::*;

    logic [3:0] r_k, n_k;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_hdr, r_end, r_ovr;

    logic       advance;
    logic [3:0] last_k;
    logic [3:0] key_start;
    logic [3:0] key_off;
    logic [7:0] ext_byte;
    logic [7:0] hdr_byte;
    logic       hdr_last;

    assign advance = i_head_valid && (!r_valid || i_ready);

    always_comb begin
        unique case (i_head.len_class)
            LEN_7:   last_k = HDR_LAST_7;
            LEN_16:  last_k = HDR_LAST_16;
            default: last_k = HDR_LAST_64;
        endcase
        key_start = last_k - 4'd3;
        key_off   = r_k - key_start;
        hdr_last  = (r_k == last_k);

        // extended length bytes
        ext_byte = 8'h00;
        if (i_head.len_class == LEN_16) begin
            ext_byte = (r_k == 4'd2) ? i_head.length[15:8] : i_head.length[7:0];
        end else begin
            case (r_k)
                4'd6:    ext_byte = i_head.length[31:24];
                4'd7:    ext_byte = i_head.length[23:16];
                4'd8:    ext_byte = i_head.length[15:8];
                4'd9:    ext_byte = i_head.length[7:0];
                default: ext_byte = 8'h00;
            endcase
        end

        if (r_k == 4'd0) begin
            hdr_byte = i_head.first_byte;
        end else if (r_k == 4'd1) begin
            unique case (i_head.len_class)
                LEN_7:   hdr_byte = {MASK_BIT, i_head.length[6:0]};
                LEN_16:  hdr_byte = {MASK_BIT, LEN_CODE_16};
                default: hdr_byte = {MASK_BIT, LEN_CODE_64};
            endcase
        end else if (r_k >= key_start) begin
            hdr_byte = key_byte(i_head.key, key_off[1:0]);
        end else begin
            hdr_byte = ext_byte;
        end

        n_k   = r_k;
        o_pop = 1'b0;
        if (advance) begin
            if (!i_head.is_hdr || hdr_last) begin
                o_pop = 1'b1;
                n_k   = 4'd0;
            end else begin
                n_k = r_k + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_k <= n_k;
            if (advance) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (i_head.is_hdr) begin
                r_byte <= hdr_byte;
                r_hdr  <= 1'b1;
                r_end  <= hdr_last && i_head.frame_end;
                r_ovr  <= 1'b0;
            end else begin
                r_byte <= i_head.first_byte;
                r_hdr  <= 1'b0;
                r_end  <= i_head.frame_end;
                r_ovr  <= i_head.overrun;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_byte      = r_byte;
    assign o_is_header = r_hdr;
    assign o_frame_end = r_end;
    assign o_overrun   = r_ovr;

    a_mid_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != 4'd0) |-> (i_head_valid && i_head.is_hdr))
        else $error("header walk without a header job at the head");
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= HDR_LAST_64)
        else $error("header byte index out of range");
    a_pop_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> advance)
        else $error("job released without a byte going out");

endmodule

### rtl/websocket_frame_encoder.sv
// Top level of the WebSocket client frame encoder.
// Turns frame-start and payload words into the masked RFC 6455 byte stream.
// A frame-start word (tuser = 0) yields the header: fin/opcode byte, mask bit
// with the length code, 0, 2 or 8 extended length bytes and the four key bytes,
// so 6, 8 or 14 output words. A payload word (tuser = 1) yields one byte XORed
// with key byte (index mod 4); a payload word with no bytes left in the frame
// goes out unmasked with the overrun flag. tlast marks the last byte of a
// frame (last key byte when the length is zero). A new frame-start word drops
// whatever remained of the previous frame.
// Rate: one output word per cycle when the sink is ready and a job is queued;
// payload words are taken one per cycle while the queue is not full. The front
// end updates frame state as each word is accepted and drops a job into a
// QUEUE_DEPTH-entry queue; the byte sequencer drains it, so a header burst
// holds the output for its 6, 8 or 14 words while the input keeps taking words
// until the queue fills. Each word passes the queue and then the output register.
module websocket_frame_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] final_flag, [4:1] frame_opcode, [36:5] payload_length,
    // [68:37] mask_key, [76:69] data_byte, [79:77] zero
    input  logic [79:0] i_s_axis_tdata,
    // [0] mode: 0 frame start, 1 payload byte
    input  logic        i_s_axis_tuser,

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_axis_tdata,
    // [0] is_header, [1] overrun
    output logic [1:0]  o_m_axis_tuser,
    // frame_end
    output logic        o_m_axis_tlast
);
    import wsfe_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd head_cmd;

    assign o_s_axis_tready = !q_full;
    assign accept          = i_s_axis_tvalid && !q_full;

    wsfe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_mode           (i_s_axis_tuser),
        .i_final_flag     (i_s_axis_tdata[0]),
        .i_frame_opcode   (i_s_axis_tdata[4:1]),
        .i_payload_length (i_s_axis_tdata[36:5]),
        .i_mask_key       (i_s_axis_tdata[68:37]),
        .i_data_byte      (i_s_axis_tdata[76:69]),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    wsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    wsfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_byte       (o_m_axis_tdata),
        .o_is_header  (o_m_axis_tuser[0]),
        .o_frame_end  (o_m_axis_tlast),
        .o_overrun    (o_m_axis_tuser[1])
    );

endmodule
